### design/b64c_pkg.sv
package b64c_pkg;

    localparam logic [7:0] CHAR_PAD = 8'h3D;  // '='
    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;
    localparam int unsigned MAX_RESULTS = 4;

    // One accepted transaction's worth of results, up to four
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] chars;
        logic [1:0]                  last_idx;
        logic                        has_data;
        logic                        eom;
    } t_bundle;

    // Sextet to alphabet character
    function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v - 6'd26};
        end else if (v < SEXTET_PLUS) begin
            c = 8'h30 + {2'b00, v - 6'd52};
        end else if (v == SEXTET_PLUS) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

    // Character to sextet; bit 6 set for a character outside the alphabet
    function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
        logic [6:0] s;
        if (c >= 8'h41 && c <= 8'h5A) begin
            s = {1'b0, 6'(c - 8'h41)};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            s = {1'b0, 6'(c - 8'h61 + 8'd26)};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s = {1'b0, 6'(c - 8'h30 + 8'd52)};
        end else if (c == 8'h2B) begin
            s = {1'b0, SEXTET_PLUS};
        end else if (c == 8'h2F) begin
            s = {1'b0, SEXTET_SLASH};
        end else begin
            s = 7'h40;
        end
        return s;
    endfunction

endpackage

### design/base64_stream_codec_core.sv
// Base64 codec (standard alphabet, '=' padding) over a byte stream. Write
// i_cfg_wdata with i_cfg_we to pick encode (0) or decode (1); any write
// also aborts the message in progress, so write only while idle. Each input
// transaction is taken and classified by the front end, which
// pushes its results (up to four) as one entry into a two-entry queue; the
// back end sends them out one per cycle, while the receiver is ready, through
// an output register. The result port therefore sets the rate: encoding gives
// four characters per three bytes (a byte that completes a group gives two
// characters), decoding at most one byte per character, and the last byte of
// an encoded message gives two to four characters with closing and padding.
// A last item that yields no data gives a single end marker with
// o_has_data low. o_message_length is nonzero only on the end-of-message
// result and saturates at all ones.
module base64_stream_codec_core #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_wdata,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_last_item,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [7:0]             o_out_byte,
    output logic                   o_has_data,
    output logic                   o_end_of_message,
    output logic [LENGTH_BITS-1:0] o_message_length
);
    import b64c_pkg::*;

    localparam int QW = $bits(t_bundle) + LENGTH_BITS;

    logic                   q_ready, q_valid, push, pop;
    t_bundle                f_bundle, q_bundle;
    logic [LENGTH_BITS-1:0] f_length, q_length;

    // Front end: classify and compute results
    b64c_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_last_item (i_last_item),
        .i_q_ready   (q_ready),
        .o_push      (push),
        .o_bundle    (f_bundle),
        .o_length    (f_length)
    );

    // Decoupling queue
    b64c_queue #(.WIDTH(QW), .DEPTH(2)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_bundle, f_length}),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  ({q_bundle, q_length})
    );

    // Back end: serialise results
    b64c_back #(.LENGTH_BITS(LENGTH_BITS)) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_bundle         (q_bundle),
        .i_length         (q_length),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_out_byte       (o_out_byte),
        .o_has_data       (o_has_data),
        .o_end_of_message (o_end_of_message),
        .o_message_length (o_message_length)
    );

`ifndef SYNTHESIS
    a_len_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_end_of_message) |-> (o_message_length == '0))
        else $error("message length on a non-final result");

    a_bare_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_has_data) |-> (o_end_of_message && o_out_byte == 8'h00))
        else $error("bare marker that is not an end of message");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid)
        else $error("queue popped while empty");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> q_ready)
        else $error("queue pushed while full");
`endif

endmodule

### design/b64c_front.sv
module b64c_front #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_wdata,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_last_item,
    input  logic                   i_q_ready,
    output logic                   o_push,
    output b64c_pkg::t_bundle      o_bundle,
    output logic [LENGTH_BITS-1:0] o_length
);
    import b64c_pkg::*;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    logic                   r_dir;
    logic [1:0]             r_phase, n_phase;
    logic [7:0]             r_carry, n_carry;
    logic                   r_stop, n_stop;
    logic [LENGTH_BITS-1:0] r_len;
    logic [LENGTH_BITS:0]   len_sum;
    logic [LENGTH_BITS-1:0] len_sat;
    logic [2:0]             nd;
    logic [MAX_RESULTS-1:0][7:0] chars;
    logic [6:0]             sx;
    logic                   accept;

    assign o_ready = i_q_ready;
    assign accept  = i_valid & i_q_ready;

    // Classify the item and work out every result it causes
    always_comb begin
        n_phase = r_phase;
        n_carry = r_carry;
        n_stop  = r_stop;
        nd      = 3'd0;
        chars   = '0;
        sx      = char_to_sextet(i_data_byte);
        if (!r_dir) begin
            case (r_phase)
                2'd1: begin
                    chars[0] = sextet_to_char(r_carry[5:0] | {2'b00, i_data_byte[7:4]});
                    n_carry  = {2'b00, i_data_byte[3:0], 2'b00};
                    n_phase  = 2'd2;
                    nd       = 3'd1;
                end
                2'd2: begin
                    chars[0] = sextet_to_char(r_carry[5:0] | {4'b0000, i_data_byte[7:6]});
                    chars[1] = sextet_to_char(i_data_byte[5:0]);
                    n_carry  = 8'h00;
                    n_phase  = 2'd0;
                    nd       = 3'd2;
                end
                default: begin
                    // phase 0, and the decode-only phase 3 alike
                    chars[0] = sextet_to_char(i_data_byte[7:2]);
                    n_carry  = {2'b00, i_data_byte[1:0], 4'b0000};
                    n_phase  = 2'd1;
                    nd       = 3'd1;
                end
            endcase
            // closing character and padding
            if (i_last_item && n_phase != 2'd0) begin
                chars[nd[1:0]] = sextet_to_char(n_carry[5:0]);
                nd = nd + 3'd1;
                if (n_phase == 2'd1) begin
                    chars[nd[1:0]] = CHAR_PAD;
                    nd = nd + 3'd1;
                end
                chars[nd[1:0]] = CHAR_PAD;
                nd = nd + 3'd1;
            end
        end else if (!r_stop) begin
            if (i_data_byte == CHAR_PAD || i_data_byte == CHAR_NUL) begin
                n_stop = 1'b1;
            end else if (!sx[6]) begin
                case (r_phase)
                    2'd0: begin
                        n_carry = {sx[5:0], 2'b00};
                    end
                    2'd1: begin
                        chars[0] = r_carry | {6'b000000, sx[5:4]};
                        n_carry  = {sx[3:0], 4'b0000};
                        nd       = 3'd1;
                    end
                    2'd2: begin
                        chars[0] = r_carry | {4'b0000, sx[5:2]};
                        n_carry  = {sx[1:0], 6'b000000};
                        nd       = 3'd1;
                    end
                    default: begin
                        chars[0] = r_carry | {2'b00, sx[5:0]};
                        n_carry  = 8'h00;
                        nd       = 3'd1;
                    end
                endcase
                n_phase = r_phase + 2'd1;
            end
        end
    end

    // Saturating message length
    assign len_sum = {1'b0, r_len} + {{(LENGTH_BITS-2){1'b0}}, nd};
    assign len_sat = len_sum[LENGTH_BITS] ? LEN_MAX : len_sum[LENGTH_BITS-1:0];

    // Bundle towards the queue; a silent non-last item pushes nothing
    assign o_push            = accept & ((nd != 3'd0) | i_last_item);
    assign o_bundle.chars    = chars;
    assign o_bundle.last_idx = (nd == 3'd0) ? 2'd0 : 2'(nd - 3'd1);
    assign o_bundle.has_data = (nd != 3'd0);
    assign o_bundle.eom      = i_last_item;
    assign o_length          = i_last_item ? len_sat : '0;

    // Message state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir   <= 1'b0;
            r_phase <= 2'd0;
            r_carry <= 8'h00;
            r_stop  <= 1'b0;
            r_len   <= '0;
        end else if (i_cfg_we) begin
            r_dir   <= i_cfg_wdata;
            r_phase <= 2'd0;
            r_carry <= 8'h00;
            r_stop  <= 1'b0;
            r_len   <= '0;
        end else if (accept) begin
            if (i_last_item) begin
                r_phase <= 2'd0;
                r_carry <= 8'h00;
                r_stop  <= 1'b0;
                r_len   <= '0;
            end else begin
                r_phase <= n_phase;
                r_carry <= n_carry;
                r_stop  <= n_stop;
                r_len   <= len_sat;
            end
        end
    end

endmodule

### design/b64c_queue.sv
module b64c_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;

    assign o_ready = (r_cnt != CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_LAST) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_LAST) ? '0 : r_rp + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

### design/b64c_back.sv
module b64c_back #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    input  b64c_pkg::t_bundle      i_bundle,
    input  logic [LENGTH_BITS-1:0] i_length,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [7:0]             o_out_byte,
    output logic                   o_has_data,
    output logic                   o_end_of_message,
    output logic [LENGTH_BITS-1:0] o_message_length
);
    import b64c_pkg::*;

    logic                   r_valid;
    logic [7:0]             r_byte;
    logic                   r_has;
    logic                   r_eom;
    logic [LENGTH_BITS-1:0] r_len;
    logic [1:0]             r_idx;
    logic                   load;
    logic                   at_end;

    assign load   = i_q_valid & (~r_valid | i_ready);
    assign at_end = (r_idx == i_bundle.last_idx);
    assign o_pop  = load & at_end;

    // Result index within the head bundle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= at_end ? 2'd0 : r_idx + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_bundle.chars[r_idx];
            r_has  <= i_bundle.has_data;
            r_eom  <= i_bundle.eom & at_end;
            r_len  <= (i_bundle.eom & at_end) ? i_length : '0;
        end
    end

    assign o_valid          = r_valid;
    assign o_out_byte       = r_byte;
    assign o_has_data       = r_has;
    assign o_end_of_message = r_eom;
    assign o_message_length = r_len;

endmodule

### tb/sv/base64_stream_codec_core_test.sv
module base64_stream_codec_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import b64c_pkg::*;

    localparam int LENGTH_BITS    = 16;
    localparam int IDLE_PCT       = 29;
    localparam int RANDOM_ITEMS   = 130;
    localparam int DRAIN_CYCLES   = 8;
    localparam int TAIL_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_PRINTED    = 20;
    localparam int PREDICTED      = -1;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    localparam logic [511:0] ALPHABET_BITS =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [7:0]             out_byte;
        logic                   has_data;
        logic                   eom;
        logic [LENGTH_BITS-1:0] len;
    } t_b64_result;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    // chars holds the typed characters right aligned, first one highest
    typedef struct packed {
        t_row_kind              kind;
        logic [7:0]             data;
        logic                   last;
        logic signed [3:0]      n_typed;
        logic [31:0]            chars;
        logic [LENGTH_BITS-1:0] len;
    } t_stim_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic                   i_cfg_wdata;
    logic                   i_valid;
    logic                   o_ready;
    logic [7:0]             i_data_byte;
    logic                   i_last_item;
    logic                   o_valid;
    logic                   i_ready;
    logic [7:0]             o_out_byte;
    logic                   o_has_data;
    logic                   o_end_of_message;
    logic [LENGTH_BITS-1:0] o_message_length;

    base64_stream_codec_core #(
        .LENGTH_BITS(LENGTH_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .i_last_item     (i_last_item),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_byte      (o_out_byte),
        .o_has_data      (o_has_data),
        .o_end_of_message(o_end_of_message),
        .o_message_length(o_message_length)
    );

    always #10 i_clk = ~i_clk;

    // Codec predictor state
    logic                   codec_dir;
    logic [1:0]             sextet_pos;
    logic [7:0]             spare_bits;
    logic                   halted;
    logic [LENGTH_BITS-1:0] emitted_total;
    t_b64_result            step_res [0:3];
    int                     step_n;

    t_b64_result pending_results [$];
    t_b64_result head_result;

    // Typed expectation travelling with the transaction on the input side
    int                     row_typed_n;
    logic [31:0]            row_chars;
    logic [LENGTH_BITS-1:0] row_len;

    logic steady;
    logic driven_dir;
    int   fail_count;
    int   stall_cycles;
    int   items_accepted;
    int   results_checked;
    int   messages_done;
    int   cfg_writes;

    function automatic logic [7:0] alpha_char(input logic [5:0] v);
        return ALPHABET_BITS[8*(63-v) +: 8];
    endfunction

    // Bit 6 set when the character is not in the alphabet
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] s;
        s = 7'd64;
        for (int i = 0; i < 64; i++) begin
            if (alpha_char(i[5:0]) == c) begin
                s = i[6:0];
            end
        end
        return s;
    endfunction

    function automatic t_stim_row mk_row(input t_row_kind kind, input logic [7:0] data,
                                         input logic last, input int n,
                                         input logic [31:0] chars,
                                         input int len);
        t_stim_row r;
        r.kind    = kind;
        r.data    = data;
        r.last    = last;
        r.n_typed = n[3:0];
        r.chars   = chars;
        r.len     = LENGTH_BITS'(len);
        return r;
    endfunction

    task automatic clear_message_state();
        sextet_pos    = 2'd0;
        spare_bits    = 8'd0;
        halted        = 1'b0;
        emitted_total = '0;
    endtask

    task automatic emit_expected(input logic [7:0] v);
        step_res[step_n] = {v, 1'b1, 1'b0, {LENGTH_BITS{1'b0}}};
        step_n++;
        if (emitted_total != {LENGTH_BITS{1'b1}}) begin
            emitted_total++;
        end
    endtask

    // Works out the results of one input transaction into step_res
    task automatic codec_predict(input logic [7:0] b, input logic last);
        logic [6:0]  sx;
        t_b64_result tail;
        step_n = 0;
        if (codec_dir == DIR_ENCODE) begin
            case (sextet_pos)
                2'd1: begin
                    emit_expected(alpha_char(spare_bits[5:0] | {2'b00, b[7:4]}));
                    spare_bits = {2'b00, b[3:0], 2'b00};
                    sextet_pos = 2'd2;
                end
                2'd2: begin
                    emit_expected(alpha_char(spare_bits[5:0] | {4'b0000, b[7:6]}));
                    emit_expected(alpha_char(b[5:0]));
                    spare_bits = 8'd0;
                    sextet_pos = 2'd0;
                end
                default: begin
                    emit_expected(alpha_char(b[7:2]));
                    spare_bits = {2'b00, b[1:0], 4'b0000};
                    sextet_pos = 2'd1;
                end
            endcase
            // closing character and padding
            if (last && sextet_pos != 2'd0) begin
                emit_expected(alpha_char(spare_bits[5:0]));
                if (sextet_pos == 2'd1) begin
                    emit_expected(CHAR_PAD);
                end
                emit_expected(CHAR_PAD);
            end
        end else if (!halted) begin
            if (b == CHAR_PAD || b == CHAR_NUL) begin
                halted = 1'b1;
            end else begin
                sx = sextet_of(b);
                if (!sx[6]) begin
                    case (sextet_pos)
                        2'd0: spare_bits = {sx[5:0], 2'b00};
                        2'd1: begin
                            emit_expected(spare_bits | {6'd0, sx[5:4]});
                            spare_bits = {sx[3:0], 4'd0};
                        end
                        2'd2: begin
                            emit_expected(spare_bits | {4'd0, sx[5:2]});
                            spare_bits = {sx[1:0], 6'd0};
                        end
                        default: begin
                            emit_expected(spare_bits | {2'd0, sx[5:0]});
                            spare_bits = 8'd0;
                        end
                    endcase
                    sextet_pos = sextet_pos + 2'd1;
                end
            end
        end
        // end of message: bare marker if nothing came out, length on the tail
        if (last) begin
            if (step_n == 0) begin
                step_res[0] = '0;
                step_n = 1;
            end
            tail = step_res[step_n-1];
            tail.eom = 1'b1;
            tail.len = emitted_total;
            step_res[step_n-1] = tail;
            clear_message_state();
        end
    endtask

    task automatic report_mismatch(input string msg);
        if (fail_count < MAX_PRINTED) begin
            $display("MISMATCH at result %0d: %s", results_checked, msg);
        end
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
        end
    endtask

    // Sample both handshakes and the register port at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            codec_dir = DIR_ENCODE;
            clear_message_state();
            stall_cycles++;
        end else begin
            if (i_cfg_we) begin
                codec_dir = i_cfg_wdata;
                clear_message_state();
            end
            if (i_valid && o_ready) begin
                codec_predict(i_data_byte, i_last_item);
                if (row_typed_n == 0) begin
                    if (i_last_item) begin
                        pending_results.push_back({8'd0, 1'b0, 1'b1, row_len});
                    end
                end else if (row_typed_n > 0) begin
                    for (int i = 0; i < row_typed_n; i++) begin
                        head_result.out_byte = row_chars[8*(row_typed_n-1-i) +: 8];
                        head_result.has_data = 1'b1;
                        head_result.eom      = i_last_item && (i == row_typed_n - 1);
                        head_result.len      = head_result.eom ? row_len : '0;
                        pending_results.push_back(head_result);
                    end
                end else begin
                    for (int i = 0; i < step_n; i++) begin
                        pending_results.push_back(step_res[i]);
                    end
                end
                items_accepted++;
            end
            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    head_result = pending_results.pop_front();
                    check_field("out_byte", {8'd0, o_out_byte},
                                {8'd0, head_result.out_byte});
                    check_field("has_data", {15'd0, o_has_data},
                                {15'd0, head_result.has_data});
                    check_field("end_of_message", {15'd0, o_end_of_message},
                                {15'd0, head_result.eom});
                    check_field("message_length", o_message_length, head_result.len);
                    if (head_result.eom) begin
                        messages_done++;
                    end
                end
                results_checked++;
            end
            if (i_cfg_we || (i_valid && o_ready) || (o_valid && i_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
    end

    // Receiver back-pressure
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            i_ready = steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input logic [7:0] d, input logic l, input int n_typed,
                             input logic [31:0] chars, input logic [LENGTH_BITS-1:0] len);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_data_byte = d;
        i_last_item = l;
        row_typed_n = n_typed;
        row_chars   = chars;
        row_len     = len;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // Register write only once the block has gone quiet
    task automatic write_direction(input logic dir);
        i_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = dir;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        driven_dir  = dir;
        cfg_writes++;
    endtask

    function automatic logic [7:0] noise_char();
        logic [7:0] c;
        logic [6:0] s;
        do begin
            c = 8'($urandom_range(0, 255));
            s = sextet_of(c);
        end while (!s[6] || c == CHAR_PAD || c == CHAR_NUL);
        return c;
    endfunction

    // Watchdog: no transaction for too long ends the run
    initial begin
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("base64_stream_codec_core_test: FAIL");
        $finish;
    end

    initial begin
        t_stim_row  directed_rows [$];
        logic [7:0] msg [$];
        int         random_items;
        int         style;
        int         count;
        int         pad;
        logic [7:0] c;

        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = 1'b0;
        i_valid         = 1'b0;
        i_data_byte     = 8'd0;
        i_last_item     = 1'b0;
        i_ready         = 1'b0;
        row_typed_n     = PREDICTED;
        row_chars       = '0;
        row_len         = '0;
        steady          = 1'b0;
        driven_dir      = DIR_ENCODE;
        fail_count      = 0;
        items_accepted  = 0;
        results_checked = 0;
        messages_done   = 0;
        cfg_writes      = 0;
        random_items    = 0;

        // Encode straight out of reset: extremes, every closing phase, an abort
        directed_rows.push_back(mk_row(ROW_ITEM, 8'h00, 1'b1, 4, "AA==", 4));
        directed_rows.push_back(mk_row(ROW_ITEM, 8'hFF, 1'b1, 4, "/w==", 4));
        directed_rows.push_back(mk_row(ROW_ITEM, 8'hFF, 1'b0, 1, 32'("/"), 0));
        directed_rows.push_back(mk_row(ROW_ITEM, 8'hFF, 1'b0, 1, 32'("/"), 0));
        directed_rows.push_back(mk_row(ROW_ITEM, 8'hFF, 1'b1, 2, 32'("//"), 4));
        directed_rows.push_back(mk_row(ROW_ITEM, 8'h00, 1'b0, 1, 32'("A"), 0));
        directed_rows.push_back(mk_row(ROW_ITEM, 8'h00, 1'b1, 3, 32'("AA="), 4));
        directed_rows.push_back(mk_row(ROW_ITEM, "M", 1'b0, PREDICTED, 0, 0));
        directed_rows.push_back(mk_row(ROW_ITEM, "a", 1'b0, PREDICTED, 0, 0));
        directed_rows.push_back(mk_row(ROW_ITEM, "n", 1'b1, PREDICTED, 0, 0));
        directed_rows.push_back(mk_row(ROW_ITEM, 8'h12, 1'b0, PREDICTED, 0, 0));
        directed_rows.push_back(mk_row(ROW_CFG, {7'd0, DIR_ENCODE}, 1'b0, PREDICTED, 0, 0));
        directed_rows.push_back(mk_row(ROW_ITEM, 8'h34, 1'b1, PREDICTED, 0, 0));
        // Decode: stop and skipped characters as last item, all-ones group
        directed_rows.push_back(mk_row(ROW_CFG, {7'd0, DIR_DECODE}, 1'b0, PREDICTED, 0, 0));
        directed_rows.push_back(mk_row(ROW_ITEM, CHAR_PAD, 1'b1, 0, 0, 0));
        directed_rows.push_back(mk_row(ROW_ITEM, CHAR_NUL, 1'b1, 0, 0, 0));
        directed_rows.push_back(mk_row(ROW_ITEM, "*", 1'b1, 0, 0, 0));
        directed_rows.push_back(mk_row(ROW_ITEM, "/", 1'b0, 0, 0, 0));
        directed_rows.push_back(mk_row(ROW_ITEM, "/", 1'b0, 1, 32'hFF, 0));
        directed_rows.push_back(mk_row(ROW_ITEM, "/", 1'b0, 1, 32'hFF, 0));
        directed_rows.push_back(mk_row(ROW_ITEM, "/", 1'b1, 1, 32'hFF, 3));
        // stop right after a skipped character, then input after the stop
        directed_rows.push_back(mk_row(ROW_ITEM, "!", 1'b0, 0, 0, 0));
        directed_rows.push_back(mk_row(ROW_ITEM, CHAR_PAD, 1'b0, 0, 0, 0));
        directed_rows.push_back(mk_row(ROW_ITEM, "Q", 1'b1, 0, 0, 0));
        // partial group at message end: its leftover bits are dropped
        directed_rows.push_back(mk_row(ROW_ITEM, "Q", 1'b0, PREDICTED, 0, 0));
        directed_rows.push_back(mk_row(ROW_ITEM, "U", 1'b1, PREDICTED, 0, 0));

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                write_direction(directed_rows[i].data[0]);
            end else begin
                send_item(directed_rows[i].data, directed_rows[i].last,
                          directed_rows[i].n_typed, directed_rows[i].chars,
                          directed_rows[i].len);
            end
        end

        // Random messages in both directions
        while (random_items < RANDOM_ITEMS) begin
            steady = (random_items >= 50 && random_items < 90);
            if ($urandom_range(0, 3) == 0) begin
                write_direction(1'($urandom_range(0, 1)));
            end
            msg.delete();
            if (driven_dir == DIR_ENCODE) begin
                count = $urandom_range(1, 10);
                for (int k = 0; k < count; k++) begin
                    case ($urandom_range(0, 9))
                        0:       msg.push_back(8'h00);
                        1:       msg.push_back(8'hFF);
                        default: msg.push_back(8'($urandom_range(0, 255)));
                    endcase
                end
            end else begin
                style = $urandom_range(0, 9);
                if (style < 6) begin
                    // whole groups, optionally padded
                    count = 4 * $urandom_range(1, 3);
                    for (int k = 0; k < count; k++) begin
                        msg.push_back(alpha_char(6'($urandom_range(0, 63))));
                    end
                    pad = $urandom_range(0, 2);
                    if (pad >= 1) begin
                        msg[count-1] = CHAR_PAD;
                    end
                    if (pad == 2) begin
                        msg[count-2] = CHAR_PAD;
                    end
                end else if (style < 8) begin
                    // broken: partial groups with stops anywhere
                    count = $urandom_range(1, 9);
                    for (int k = 0; k < count; k++) begin
                        pad = $urandom_range(0, 99);
                        if (pad < 80) begin
                            msg.push_back(alpha_char(6'($urandom_range(0, 63))));
                        end else if (pad < 90) begin
                            msg.push_back(CHAR_PAD);
                        end else begin
                            msg.push_back(CHAR_NUL);
                        end
                    end
                end else begin
                    count = $urandom_range(1, 8);
                    for (int k = 0; k < count; k++) begin
                        msg.push_back(8'($urandom_range(0, 255)));
                    end
                end
            end
            foreach (msg[k]) begin
                if (driven_dir == DIR_DECODE && $urandom_range(0, 9) == 0) begin
                    send_item(noise_char(), 1'b0, PREDICTED, 0, '0);
                    random_items++;
                end
                c = msg[k];
                send_item(c, k == msg.size() - 1, PREDICTED, 0, '0);
                random_items++;
            end
        end
        steady = 1'b0;

        // Let the last results out, then a quiet tail to catch extras
        i_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Run covered %0d input transactions, %0d results in %0d messages, %0d writes",
                 items_accepted, results_checked, messages_done, cfg_writes);
        $display("Directed edges and random encode/decode traffic; %0d %s",
                 fail_count, "mismatches");
        if (fail_count == 0) begin
            $display("base64_stream_codec_core_test: PASS");
        end else begin
            $display("base64_stream_codec_core_test: FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
design/b64c_pkg.sv
design/b64c_front.sv
design/b64c_queue.sv
design/b64c_back.sv
design/base64_stream_codec_core.sv
tb/sv/base64_stream_codec_core_test.sv
